FILE: src/imsf_pkg.sv
// ----------------------------------------------------------------------------
// imsf_pkg
// Shared widths, register indexes and stream packing for the major state
// finder.
// ----------------------------------------------------------------------------
`default_nettype none

package imsf_pkg;

  // Field widths
  localparam int TIME_W  = 64;
  localparam int STATE_W = 4;

  // Default number of tracked states
  localparam int NUM_STATES_DEF = 16;

  // Input stream: event_start, event_end, event_state, padded to bytes
  localparam int IN_FIELDS_W = 2 * TIME_W + STATE_W;
  localparam int IN_TDATA_W  = ((IN_FIELDS_W + 7) / 8) * 8;

  // Output stream: winning_state, padded to bytes
  localparam int OUT_TDATA_W = ((STATE_W + 7) / 8) * 8;

  // Configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = TIME_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WINDOW_START = 1'b0,
    REG_WINDOW_END   = 1'b1
  } cfg_reg_t;

endpackage

`default_nettype wire

FILE: src/interval_major_state_finder.sv
// ----------------------------------------------------------------------------
// interval_major_state_finder
// Accumulates per-state time spent inside a query window and reports the
// major state on the last event of each query.
// ----------------------------------------------------------------------------
// Set window_start and window_end, then stream events (start, end, state)
// with tlast on the final event of the query. Each event is clipped to the
// window and its length added to that state's 64-bit sum (wrapping). The
// first state whose sum exceeds half the window length is decided at once
// and later events of the query add nothing. On the last event one item is
// sent: tuser holds found, tdata the major state (the decided state, else
// the state with the largest nonzero sum, lower id on a tie, else 0). All
// sums are then cleared for the next query.
// The block takes one event in every cycle unless a last event finds no room
// in the search tree. A result passes the input register, the accumulate
// stage, the leaf snapshot, the registered compare tree over the sums and
// the result register. Every stage has its own handshake, so events keep
// flowing while a result waits on m_tready until the stages fill.
// ----------------------------------------------------------------------------
`default_nettype none

module interval_major_state_finder
  import imsf_pkg::*;
#(
  parameter int NUM_STATES = NUM_STATES_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  // configuration write port
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  // event stream
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  input  wire logic [IN_TDATA_W-1:0] s_tdata,   // event_start, event_end, event_state
  input  wire logic                  s_tlast,   // last_event
  // result stream
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  output logic [OUT_TDATA_W-1:0]     m_tdata,   // winning_state
  output logic                       m_tuser    // found
);

  localparam int LEVELS = $clog2(NUM_STATES);
  localparam int IDX_W  = LEVELS;
  localparam int LEAVES = 1 << LEVELS;
  localparam int NODES  = 2 * LEAVES - 1;

  // --------------------------------------------------------------------------
  // Configuration registers; half the window length is held registered so
  // the decision compare starts from a flop.
  // --------------------------------------------------------------------------
  logic [TIME_W-1:0] window_start;
  logic [TIME_W-1:0] window_end;
  logic [TIME_W-1:0] half_len;
  logic [TIME_W-1:0] window_len;

  assign window_len = window_end - window_start;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_start <= '0;
      window_end   <= '0;
      half_len     <= '0;
    end else begin
      half_len <= window_len >> 1;
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          REG_WINDOW_START: window_start <= cfg_data;
          REG_WINDOW_END:   window_end   <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  // --------------------------------------------------------------------------
  // Handshake chain. Each stage loads when it is empty or its item moves on.
  // --------------------------------------------------------------------------
  logic              p0_valid;
  logic              p1_valid;
  logic              p1_last;
  logic [LEVELS:0]   lvl_valid;
  logic [LEVELS+1:0] lvl_load;
  logic              p0_load;
  logic              p1_load;
  logic              p1_leave;

  always_comb begin
    lvl_load[LEVELS+1] = !m_tvalid || m_tready;
    for (int l = LEVELS; l >= 0; l--) begin
      lvl_load[l] = !lvl_valid[l] || lvl_load[l+1];
    end
  end

  // Ordinary events retire at p1; only the last event of a query needs room
  // in the search tree.
  assign p1_leave = p1_valid && (!p1_last || lvl_load[0]);
  assign p1_load  = !p1_valid || p1_leave;
  assign p0_load  = !p0_valid || p1_load;
  assign s_tready = p0_load;

  // --------------------------------------------------------------------------
  // Stage p0: input register
  // --------------------------------------------------------------------------
  logic [TIME_W-1:0]  p0_start;
  logic [TIME_W-1:0]  p0_end;
  logic [STATE_W-1:0] p0_state;
  logic               p0_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      p0_valid <= 1'b0;
    end else if (p0_load) begin
      p0_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (p0_load && s_tvalid) begin
      p0_start <= s_tdata[TIME_W-1:0];
      p0_end   <= s_tdata[2*TIME_W-1:TIME_W];
      p0_state <= s_tdata[IN_FIELDS_W-1:2*TIME_W];
      p0_last  <= s_tlast;
    end
  end

  // --------------------------------------------------------------------------
  // Clip the event to the window.
  // --------------------------------------------------------------------------
  logic [TIME_W-1:0] clip_lo;
  logic [TIME_W-1:0] clip_hi;
  logic [TIME_W-1:0] overlap;

  assign clip_lo = (p0_start > window_start) ? p0_start : window_start;
  assign clip_hi = (p0_end < window_end) ? p0_end : window_end;
  assign overlap = (clip_hi > clip_lo) ? (clip_hi - clip_lo) : '0;

  // --------------------------------------------------------------------------
  // Stage p1: clipped length, accumulate into the state's sum
  // --------------------------------------------------------------------------
  logic [TIME_W-1:0]  p1_overlap;
  logic [STATE_W-1:0] p1_state;

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid <= 1'b0;
    end else if (p1_load) begin
      p1_valid <= p0_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (p1_load && p0_valid) begin
      p1_overlap <= overlap;
      p1_state   <= p0_state;
      p1_last    <= p0_last;
    end
  end

  logic [TIME_W-1:0]        sums [NUM_STATES];
  logic                     decided;
  logic [STATE_W-1:0]       decided_state;
  logic [IDX_W+STATE_W-1:0] p1_state_ext;
  logic [IDX_W-1:0]         p1_idx;
  logic                     in_range;
  logic                     upd_en;
  logic [TIME_W-1:0]        cur_sum;
  logic [TIME_W-1:0]        new_sum;
  logic                     crossed;
  logic                     snap_decided;
  logic [STATE_W-1:0]       snap_state;

  assign p1_state_ext = {{IDX_W{1'b0}}, p1_state};
  assign p1_idx       = p1_state_ext[IDX_W-1:0];
  assign in_range     = int'(p1_state) < NUM_STATES;
  assign upd_en       = !decided && in_range;
  assign cur_sum      = in_range ? sums[p1_idx] : '0;
  assign new_sum      = cur_sum + p1_overlap;
  assign crossed      = upd_en && (new_sum > half_len);
  assign snap_decided = decided || crossed;
  assign snap_state   = decided ? decided_state : p1_state;

  always_ff @(posedge clk) begin
    if (rst) begin
      decided       <= 1'b0;
      decided_state <= '0;
      for (int i = 0; i < NUM_STATES; i++) begin
        sums[i] <= '0;
      end
    end else if (p1_leave) begin
      if (p1_last) begin
        // Query done: clear for the next one
        decided       <= 1'b0;
        decided_state <= '0;
        for (int i = 0; i < NUM_STATES; i++) begin
          sums[i] <= '0;
        end
      end else if (upd_en) begin
        sums[p1_idx] <= new_sum;
        if (crossed) begin
          decided       <= 1'b1;
          decided_state <= p1_state;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Search tree. Nodes are kept heap-ordered: root at 0, leaves from
  // LEAVES-1 upward. On a tie the left (lower id) node wins.
  // --------------------------------------------------------------------------
  logic [TIME_W-1:0]  tree_sum [NODES];
  logic [IDX_W-1:0]   tree_idx [NODES];
  logic               lvl_dec   [LEVELS+1];
  logic [STATE_W-1:0] lvl_state [LEVELS+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      lvl_valid <= '0;
    end else begin
      if (lvl_load[0]) begin
        lvl_valid[0] <= p1_leave && p1_last;
      end
      for (int l = 1; l <= LEVELS; l++) begin
        if (lvl_load[l]) begin
          lvl_valid[l] <= lvl_valid[l-1];
        end
      end
    end
  end

  // Leaves: snapshot of the sums including the last event's own update
  always_ff @(posedge clk) begin
    if (lvl_load[0] && p1_leave && p1_last) begin
      lvl_dec[0]   <= snap_decided;
      lvl_state[0] <= snap_state;
    end
  end

  for (genvar i = 0; i < LEAVES; i++) begin : g_leaf
    if (i < NUM_STATES) begin : g_real
      always_ff @(posedge clk) begin
        if (lvl_load[0] && p1_leave && p1_last) begin
          tree_sum[LEAVES-1+i] <= (upd_en && (p1_idx == IDX_W'(i))) ? new_sum : sums[i];
          tree_idx[LEAVES-1+i] <= IDX_W'(i);
        end
      end
    end else begin : g_pad
      always_ff @(posedge clk) begin
        if (lvl_load[0] && p1_leave && p1_last) begin
          tree_sum[LEAVES-1+i] <= '0;
          tree_idx[LEAVES-1+i] <= IDX_W'(i);
        end
      end
    end
  end

  for (genvar l = 1; l <= LEVELS; l++) begin : g_level
    localparam int BASE  = (LEAVES >> l) - 1;
    localparam int CBASE = (LEAVES >> (l - 1)) - 1;

    always_ff @(posedge clk) begin
      if (lvl_load[l] && lvl_valid[l-1]) begin
        lvl_dec[l]   <= lvl_dec[l-1];
        lvl_state[l] <= lvl_state[l-1];
      end
    end

    for (genvar j = 0; j < (LEAVES >> l); j++) begin : g_node
      logic right_wins;
      assign right_wins = tree_sum[CBASE+2*j+1] > tree_sum[CBASE+2*j];

      always_ff @(posedge clk) begin
        if (lvl_load[l] && lvl_valid[l-1]) begin
          tree_sum[BASE+j] <= right_wins ? tree_sum[CBASE+2*j+1] : tree_sum[CBASE+2*j];
          tree_idx[BASE+j] <= right_wins ? tree_idx[CBASE+2*j+1] : tree_idx[CBASE+2*j];
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result register
  // --------------------------------------------------------------------------
  logic                     root_nonzero;
  logic [IDX_W+STATE_W-1:0] root_idx_ext;
  logic                     res_found;
  logic [STATE_W-1:0]       res_state;

  assign root_nonzero = tree_sum[0] != '0;
  assign root_idx_ext = {{STATE_W{1'b0}}, tree_idx[0]};
  assign res_found    = lvl_dec[LEVELS] || root_nonzero;
  assign res_state    = lvl_dec[LEVELS] ? lvl_state[LEVELS] :
                        root_nonzero    ? root_idx_ext[STATE_W-1:0] : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (lvl_load[LEVELS+1]) begin
      m_tvalid <= lvl_valid[LEVELS];
    end
  end

  always_ff @(posedge clk) begin
    if (lvl_load[LEVELS+1] && lvl_valid[LEVELS]) begin
      m_tuser <= res_found;
      m_tdata <= {{(OUT_TDATA_W-STATE_W){1'b0}}, res_state};
    end
  end

endmodule

`default_nettype wire

FILE: src/imsf_checker.sv
// ----------------------------------------------------------------------------
// imsf_checker
// Port-level checks on the major state finder, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module imsf_checker
  import imsf_pkg::*;
(
  input wire logic                   clk,
  input wire logic                   rst,
  input wire logic                   s_tvalid,
  input wire logic                   s_tready,
  input wire logic                   s_tlast,
  input wire logic                   m_tvalid,
  input wire logic                   m_tready,
  input wire logic [OUT_TDATA_W-1:0] m_tdata,
  input wire logic                   m_tuser
);

  // Queries whose last item is taken but whose result is not yet delivered
  logic [7:0] pending;
  logic       last_in;
  logic       res_out;

  assign last_in = s_tvalid && s_tready && s_tlast;
  assign res_out = m_tvalid && m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      pending <= pending + {7'd0, last_in} - {7'd0, res_out};
    end
  end

  // Hold a stalled result
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

  // Every result answers a last item
  a_no_invented: assert property (@(posedge clk) disable iff (rst)
    res_out |-> (pending != 8'd0) || last_in)
    else $error("result without a pending query");

  // Major state reads zero when nothing was found
  a_zero_when_none: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> m_tdata == '0)
    else $error("major state nonzero without found");

  // Padding bits stay clear
  a_pad_clear: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[OUT_TDATA_W-1:STATE_W] == '0)
    else $error("padding bits set in result");

endmodule

bind interval_major_state_finder imsf_checker u_imsf_checker (.*);

`default_nettype wire

FILE: dv/major_state_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// major_state_checker
// Watches the configuration port and both streams of the major state finder.
// It predicts the verdict of each query and compares it with every result.
// ----------------------------------------------------------------------------
module major_state_checker
  import imsf_pkg::*;
#(
  parameter int NUM_STATES = NUM_STATES_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  s_tvalid,
  input  logic                  s_tready,
  input  logic [IN_TDATA_W-1:0] s_tdata,   // event_start, event_end, event_state
  input  logic                  s_tlast,   // last_event
  input  logic                  m_tvalid,
  input  logic                  m_tready,
  input  logic [OUT_TDATA_W-1:0] m_tdata,  // winning_state
  input  logic                  m_tuser,   // found
  output int                    mismatch_count,
  output int                    results_pending
);

  typedef struct packed {
    logic               found;
    logic [STATE_W-1:0] major;
  } verdict_t;

  logic [TIME_W-1:0]  win_start;
  logic [TIME_W-1:0]  win_end;
  logic [TIME_W-1:0]  state_time [NUM_STATES];
  logic               decided;
  logic [STATE_W-1:0] decided_id;
  verdict_t           awaited_verdicts [$];

  function automatic logic [TIME_W-1:0] overlap(input logic [TIME_W-1:0] t0,
                                                input logic [TIME_W-1:0] t1);
    logic [TIME_W-1:0] lo;
    logic [TIME_W-1:0] hi;
    lo = (t0 > win_start) ? t0 : win_start;
    hi = (t1 < win_end) ? t1 : win_end;
    return (hi > lo) ? hi - lo : '0;
  endfunction

  task automatic clear_query();
    for (int i = 0; i < NUM_STATES; i++) state_time[i] = '0;
    decided    = 1'b0;
    decided_id = '0;
  endtask

  task automatic take_event(input logic [TIME_W-1:0]  t0,
                            input logic [TIME_W-1:0]  t1,
                            input logic [STATE_W-1:0] id,
                            input logic               last);
    logic [TIME_W-1:0] half;
    logic [TIME_W-1:0] best;
    verdict_t          v;
    half = (win_end - win_start) >> 1;
    if (!decided && int'(id) < NUM_STATES) begin
      state_time[id] = state_time[id] + overlap(t0, t1);
      if (state_time[id] > half) begin
        decided    = 1'b1;
        decided_id = id;
      end
    end
    if (last) begin
      if (decided) begin
        v.found = 1'b1;
        v.major = decided_id;
      end else begin
        best    = '0;
        v.major = '0;
        for (int i = 0; i < NUM_STATES; i++) begin
          if (state_time[i] > best) begin
            best    = state_time[i];
            v.major = STATE_W'(i);
          end
        end
        v.found = (best != '0);
      end
      awaited_verdicts.push_back(v);
      clear_query();
    end
  endtask

  always @(posedge clk) begin
    verdict_t want;
    if (rst) begin
      win_start      = '0;
      win_end        = '0;
      mismatch_count = 0;
      clear_query();
      awaited_verdicts.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        if (awaited_verdicts.size() == 0) begin
          $error("unexpected result: found %0d winning_state %0d",
                 m_tuser, m_tdata[STATE_W-1:0]);
          mismatch_count++;
        end else begin
          want = awaited_verdicts.pop_front();
          if (m_tuser !== want.found) begin
            $error("found: expected %0d, actual %0d", want.found, m_tuser);
            mismatch_count++;
          end
          if (m_tdata[STATE_W-1:0] !== want.major) begin
            $error("winning_state: expected %0d, actual %0d",
                   want.major, m_tdata[STATE_W-1:0]);
            mismatch_count++;
          end
        end
      end
      if (s_tvalid && s_tready)
        take_event(s_tdata[TIME_W-1:0], s_tdata[2*TIME_W-1:TIME_W],
                   s_tdata[2*TIME_W +: STATE_W], s_tlast);
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          REG_WINDOW_START: win_start = cfg_data;
          REG_WINDOW_END:   win_end   = cfg_data;
          default: ;
        endcase
      end
    end
    results_pending = awaited_verdicts.size();
  end

endmodule

FILE: dv/interval_major_state_finder_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// interval_major_state_finder_test
// Drives windows and event queries into the major state finder and gives the
// verdict. A directed set of queries covers clipping corners, ties, early
// decisions and degenerate windows; random queries follow under several
// windows while the result side stalls on its own pattern.
// ----------------------------------------------------------------------------
module interval_major_state_finder_test;
  import imsf_pkg::*;

  localparam int NSTATE = NUM_STATES_DEF;
  // Cycles to let pass after the last result before touching the window
  localparam int SETTLE_CYCLES = 2 * ($clog2(NSTATE) + 3);
  localparam logic [TIME_W-1:0] T_MAX = '1;

  typedef enum int {RX_FREE, RX_LIGHT, RX_HEAVY, RX_PATTERN} rx_mode_t;

  logic                   clk;
  logic                   rst;
  logic                   cfg_we;
  logic [CFG_IDX_W-1:0]   cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;
  logic                   s_tvalid;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata;
  logic                   s_tlast;
  logic                   m_tvalid;
  logic                   m_tready;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic                   m_tuser;

  int mismatch_count;
  int results_pending;

  // Stimulus control shared between the sender and the receiver
  int                burst_left;
  bit                steady_tx;
  rx_mode_t          rx_mode;
  bit                rx_hold_req;
  int                events_sent;
  logic [TIME_W-1:0] cur_lo;
  logic [TIME_W-1:0] cur_hi;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  interval_major_state_finder #(
    .NUM_STATES(NSTATE)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  major_state_checker #(
    .NUM_STATES(NSTATE)
  ) i_checker (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .s_tvalid       (s_tvalid),
    .s_tready       (s_tready),
    .s_tdata        (s_tdata),
    .s_tlast        (s_tlast),
    .m_tvalid       (m_tvalid),
    .m_tready       (m_tready),
    .m_tdata        (m_tdata),
    .m_tuser        (m_tuser),
    .mismatch_count (mismatch_count),
    .results_pending(results_pending)
  );

  // Receiver: stall on the current mode, or hold off for a long stretch
  // when asked, so that the block backs up and stalls its input
  initial begin
    int hold_left;
    int beat;
    hold_left = 0;
    beat      = 0;
    m_tready  = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        hold_left   = 400;
      end
      beat++;
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        case (rx_mode)
          RX_FREE:  m_tready <= 1'b1;
          RX_LIGHT: m_tready <= ($urandom_range(0, 99) >= 25);
          RX_HEAVY: m_tready <= ($urandom_range(0, 99) >= 75);
          default:  m_tready <= ((beat % 7) < 3);
        endcase
      end
    end
  end

  // Offer one item from a falling edge; return at the falling edge after it
  // is taken. Valid stays high across a burst and drops only in gaps.
  task automatic send_event(input logic [TIME_W-1:0]  t0,
                            input logic [TIME_W-1:0]  t1,
                            input logic [STATE_W-1:0] id,
                            input logic               last);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = steady_tx ? 0 : $urandom_range(0, 5);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tdata  <= IN_TDATA_W'({id, t1, t0});
    s_tlast  <= last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
  endtask

  // Stop offering, wait for every awaited result, then let the pipe settle
  task automatic drain();
    s_tvalid <= 1'b0;
    do @(negedge clk); while (results_pending != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic set_window(input logic [TIME_W-1:0] lo,
                            input logic [TIME_W-1:0] hi);
    drain();
    cfg_we    <= 1'b1;
    cfg_index <= REG_WINDOW_START;
    cfg_data  <= lo;
    @(negedge clk);
    cfg_index <= REG_WINDOW_END;
    cfg_data  <= hi;
    @(negedge clk);
    cfg_we    <= 1'b0;
    cur_lo    = lo;
    cur_hi    = hi;
  endtask

  function automatic logic [TIME_W-1:0] rand_time();
    return {$urandom, $urandom};
  endfunction

  // Mostly land inside the window, sometimes just outside it or anywhere
  function automatic logic [TIME_W-1:0] pick_time();
    logic [TIME_W-1:0] span;
    span = cur_hi - cur_lo;
    case ($urandom_range(0, 9))
      0:       pick_time = rand_time();
      1:       pick_time = cur_lo - $urandom_range(0, 64);
      2:       pick_time = cur_hi + $urandom_range(0, 64);
      default: pick_time = (span == '0) ? cur_lo : cur_lo + rand_time() % span;
    endcase
  endfunction

  task automatic random_query(input int max_events);
    int                 n;
    int                 pool;
    logic [TIME_W-1:0]  t0;
    logic [TIME_W-1:0]  t1;
    logic [TIME_W-1:0]  span;
    logic [STATE_W-1:0] id;
    n    = $urandom_range(1, max_events);
    // A narrow pool of ids makes ties and early decisions likely
    pool = $urandom_range(1, 15);
    span = cur_hi - cur_lo;
    for (int k = 0; k < n; k++) begin
      t0 = pick_time();
      if ($urandom_range(0, 9) < 7)
        t1 = t0 + rand_time() % (span / 3 + 2);
      else
        t1 = pick_time();
      if ($urandom_range(0, 9) == 0)
        id = STATE_W'($urandom);
      else
        id = STATE_W'($urandom_range(0, pool));
      send_event(t0, t1, id, k == n - 1);
    end
    events_sent += n;
  endtask

  initial begin
    logic [TIME_W-1:0] lo;
    int                target;
    rst         = 1'b1;
    cfg_we      = 1'b0;
    cfg_index   = REG_WINDOW_START;
    cfg_data    = '0;
    s_tvalid    = 1'b0;
    s_tdata     = '0;
    s_tlast     = 1'b0;
    burst_left  = 0;
    steady_tx   = 1'b0;
    rx_mode     = RX_LIGHT;
    rx_hold_req = 1'b0;
    events_sent = 0;
    cur_lo      = '0;
    cur_hi      = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed queries; half the window is 500
    set_window(64'd1000, 64'd2000);
    // equal sums: the lower id wins; the last event lies past the window
    send_event(64'd1100, 64'd1300, 4'd3, 1'b0);
    send_event(64'd1500, 64'd1700, 4'd5, 1'b0);
    send_event(64'd2500, 64'd2600, 4'd7, 1'b1);
    // nothing overlaps: before the window, reversed event, touching the end
    send_event(64'd0, 64'd999, 4'd1, 1'b0);
    send_event(64'd1800, 64'd1200, 4'd2, 1'b0);
    send_event(64'd2000, 64'd3000, 4'd4, 1'b1);
    // decide at once on a full span event; later events are ignored
    send_event(64'd0, T_MAX, 4'd15, 1'b0);
    send_event(64'd1000, 64'd2000, 4'd0, 1'b0);
    send_event(64'd1000, 64'd2000, 4'd1, 1'b1);
    // all-ones times, then one past half and exactly half
    send_event(T_MAX, T_MAX, 4'd0, 1'b1);
    send_event(64'd1000, 64'd1501, 4'd0, 1'b1);
    send_event(64'd1000, 64'd1500, 4'd9, 1'b1);
    // decision built up over two events of one state
    send_event(64'd1000, 64'd1300, 4'd6, 1'b0);
    send_event(64'd1300, 64'd1600, 4'd6, 1'b0);
    send_event(64'd1000, 64'd2000, 4'd2, 1'b1);
    // unsorted events summed the same way
    send_event(64'd1900, 64'd1950, 4'd11, 1'b0);
    send_event(64'd1010, 64'd1020, 4'd12, 1'b0);
    send_event(64'd1200, 64'd1300, 4'd12, 1'b1);
    // reversed window: nothing can overlap
    set_window(T_MAX, 64'd0);
    send_event(64'd0, T_MAX, 4'd8, 1'b0);
    send_event(64'd5, 64'd10, 4'd3, 1'b1);
    // widest window
    set_window(64'd0, T_MAX);
    send_event(64'd0, T_MAX, 4'd8, 1'b1);
    send_event(64'd0, 64'd1, 4'd14, 1'b1);
    // empty window: half is zero, yet no event overlaps
    set_window(64'd0, 64'd0);
    send_event(64'd0, T_MAX, 4'd1, 1'b1);
    events_sent = 23;

    // Random queries under a run of windows
    for (int p = 0; p < 8; p++) begin
      case (p)
        0: set_window(64'd0, T_MAX);
        1: set_window(T_MAX, 64'd0);
        2: set_window(64'd0, 64'd0);
        3: set_window(T_MAX - 64'd4000, T_MAX);
        default: begin
          lo = rand_time();
          set_window(lo, lo + $urandom_range(2, 5000));
        end
      endcase
      rx_mode   = rx_mode_t'($urandom_range(0, 3));
      steady_tx = ($urandom_range(0, 3) == 0);
      target    = events_sent + 190;
      if (p == 4) begin
        // Hold the receiver off and keep offering short queries
        steady_tx   = 1'b1;
        rx_hold_req = 1'b1;
        repeat (60) random_query(1);
      end
      while (events_sent < target) begin
        random_query(8);
        // Pause mid-phase until every result is home
        if (p == 5 && events_sent >= target - 95 && events_sent < target - 87)
          drain();
      end
    end

    drain();
    if (mismatch_count == 0 && results_pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Give up on a hung run
  initial begin
    #1000000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

FILE: sim.f
src/imsf_pkg.sv
src/interval_major_state_finder.sv
src/imsf_checker.sv
dv/major_state_checker.sv
dv/interval_major_state_finder_test.sv
